FILE: hw/rtl/rv32i_pkg.sv
// ----------------------------------------------------------------------------
// RV32I executor package
// Shared sizes, opcodes and state codes for the RV32I instruction executor.
// ----------------------------------------------------------------------------
package rv32i_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int ROWS      = MEM_BYTES / 4;
    localparam int ROW_AW    = MEM_AW - 2;
    localparam int NREGS     = 32;
    localparam int REG_AW    = 5;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [31:0] BYTE_EXT = 32'hFFFFFF00;
    localparam logic [31:0] HALF_EXT = 32'hFFFF0000;
    localparam logic [31:0] PC_STEP  = 32'd4;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_RUN   = 3'b010,
        ST_LOAD  = 3'b100
    } state_t;

endpackage

FILE: hw/rtl/rv32i_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module rv32i_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/rv32i_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// RV32I instruction executor
// Executes one RV32I instruction item against pc, register file and data memory.
// ----------------------------------------------------------------------------
// After reset the block clears the data memory, one 32-bit row per cycle, while
// item_stall is high. Each instruction then has its operands read from the
// register file RAMs in the cycle it is accepted and executes once the output
// register is free; ALU, jump, branch and store items follow one per cycle unless
// result_stall holds the output. A load waits in the load state for the data
// memory read, and the next item is accepted as the load result is produced.
// Results are held in an output register; start_pc writes load the pc directly.
module rv32i_instruction_executor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] start_pc,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [31:0] instruction,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] next_pc,
    output logic        reg_write,
    output logic [4:0]  reg_index,
    output logic [31:0] reg_value,
    output logic        branch_taken,
    output logic        store_valid,
    output logic [31:0] store_address,
    output logic [31:0] store_data,
    output logic [1:0]  store_size,
    output logic        illegal
);
    import rv32i_pkg::*;

    function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                        input logic [31:0] a, input logic [31:0] b);
        logic [4:0] sh;
        logic [31:0] r;
        sh = b[4:0];
        unique case (f3)
            F3_ADD:  r = alt ? a - b : a + b;
            F3_SLL:  r = a << sh;
            F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
            F3_SLTU: r = {31'd0, a < b};
            F3_XOR:  r = a ^ b;
            F3_SR:   r = alt ? 32'($signed(a) >>> sh) : a >> sh;
            F3_OR:   r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [ROW_AW-1:0] clr_reg;
    logic [31:0] pc_reg;
    logic [NREGS-1:0] rv_reg;

    logic ex_valid_reg;
    logic [31:0] ins_reg;
    logic v1_reg, v2_reg, f1_reg, f2_reg;
    logic [31:0] fv1_reg, fv2_reg;

    logic [31:0] ld_npc_reg;
    logic [4:0] ld_rd_reg;
    logic ld_wr_reg;
    logic [2:0] ld_f3_reg;
    logic [1:0] ld_off_reg;

    logic out_valid_reg;

    logic [31:0] q1, q2;
    logic out_free, accept, ex_fire, ld_go, ld_fire;
    logic wb_en;
    logic [4:0] wb_idx;
    logic [31:0] wb_val;

    // execute decode
    logic [6:0] opc, f7;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, imm_u, ls_addr, npc, val;
    logic wr, taken, st, ill, is_load;

    logic [31:0] ld_raw, ld_val;

    logic [ROW_AW-1:0] bank_row [4];
    logic bank_we [4];
    logic [7:0] bank_wd [4];
    logic [7:0] bank_q [4];

    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        opc = ins_reg[6:0];
        rd = ins_reg[11:7];
        f3 = ins_reg[14:12];
        f7 = ins_reg[31:25];
        a = f1_reg ? fv1_reg : (v1_reg ? q1 : 32'd0);
        b = f2_reg ? fv2_reg : (v2_reg ? q2 : 32'd0);
        imm_i = {{20{ins_reg[31]}}, ins_reg[31:20]};
        imm_s = {{20{ins_reg[31]}}, ins_reg[31:25], ins_reg[11:7]};
        imm_b = {{19{ins_reg[31]}}, ins_reg[31], ins_reg[7], ins_reg[30:25],
                 ins_reg[11:8], 1'b0};
        imm_j = {{11{ins_reg[31]}}, ins_reg[31], ins_reg[19:12], ins_reg[20],
                 ins_reg[30:21], 1'b0};
        imm_u = {ins_reg[31:12], 12'd0};
        ls_addr = a + ((opc == OPC_STORE) ? imm_s : imm_i);
        npc = pc_reg + PC_STEP;
        val = 32'd0;
        wr = 1'b0;
        taken = 1'b0;
        st = 1'b0;
        ill = 1'b0;
        is_load = 1'b0;
        unique case (opc)
            OPC_OP:
            begin
                if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)))
                begin
                    val = alu(f3, f7 == F7_ALT, a, b);
                    wr = 1'b1;
                end
                else
                begin
                    ill = 1'b1;
                end
            end
            OPC_OP_IMM:
            begin
                if ((f3 == F3_SLL && f7 != F7_BASE)
                    || (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT))
                begin
                    ill = 1'b1;
                end
                else
                begin
                    val = alu(f3, f3 == F3_SR && f7 == F7_ALT, a, imm_i);
                    wr = 1'b1;
                end
            end
            OPC_LOAD:
            begin
                if (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU
                    || f3 == F3_LHU)
                begin
                    is_load = 1'b1;
                    wr = 1'b1;
                end
                else
                begin
                    ill = 1'b1;
                end
            end
            OPC_STORE:
            begin
                if (f3 <= 3'd2)
                begin
                    st = 1'b1;
                end
                else
                begin
                    ill = 1'b1;
                end
            end
            OPC_LUI:
            begin
                val = imm_u;
                wr = 1'b1;
            end
            OPC_AUIPC:
            begin
                val = pc_reg + imm_u;
                wr = 1'b1;
            end
            OPC_JAL:
            begin
                npc = pc_reg + imm_j;
                val = pc_reg + PC_STEP;
                wr = 1'b1;
                taken = 1'b1;
            end
            OPC_JALR:
            begin
                if (f3 == 3'd0)
                begin
                    npc = (a + imm_i) & ~32'd1;
                    val = pc_reg + PC_STEP;
                    wr = 1'b1;
                    taken = 1'b1;
                end
                else
                begin
                    ill = 1'b1;
                end
            end
            OPC_BRANCH:
            begin
                unique case (f3)
                    F3_BEQ:  taken = a == b;
                    F3_BNE:  taken = a != b;
                    F3_BLT:  taken = $signed(a) < $signed(b);
                    F3_BGE:  taken = !($signed(a) < $signed(b));
                    F3_BLTU: taken = a < b;
                    F3_BGEU: taken = a >= b;
                    default: ill = 1'b1;
                endcase
                if (taken)
                begin
                    npc = pc_reg + imm_b;
                end
            end
            default: ill = 1'b1;
        endcase
        if (rd == 5'd0)
        begin
            wr = 1'b0;
        end
    end

    assign ld_go = (state_reg == ST_RUN) && ex_valid_reg && is_load;
    assign ex_fire = (state_reg == ST_RUN) && ex_valid_reg && !is_load && out_free;
    assign ld_fire = (state_reg == ST_LOAD) && out_free;
    assign accept = item_valid && !item_stall;

    always_comb
    begin
        unique case (state_reg)
            ST_RUN:  item_stall = ex_valid_reg && !ex_fire;
            ST_LOAD: item_stall = !ld_fire;
            default: item_stall = 1'b1;
        endcase
    end

    // load data assembly, byte i from bank (offset + i)
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ld_raw[8*i +: 8] = bank_q[2'(ld_off_reg + 2'(i))];
        end
        unique case (ld_f3_reg)
            F3_LB:   ld_val = ld_raw[7] ? ({24'd0, ld_raw[7:0]} | BYTE_EXT)
                                        : {24'd0, ld_raw[7:0]};
            F3_LH:   ld_val = ld_raw[15] ? ({16'd0, ld_raw[15:0]} | HALF_EXT)
                                         : {16'd0, ld_raw[15:0]};
            F3_LBU:  ld_val = {24'd0, ld_raw[7:0]};
            F3_LHU:  ld_val = {16'd0, ld_raw[15:0]};
            default: ld_val = ld_raw;
        endcase
    end

    always_comb
    begin
        wb_en = 1'b0;
        wb_idx = rd;
        wb_val = val;
        if (ex_fire && wr && !ill)
        begin
            wb_en = 1'b1;
        end
        else if (ld_fire && ld_wr_reg)
        begin
            wb_en = 1'b1;
            wb_idx = ld_rd_reg;
            wb_val = ld_val;
        end
    end

    // data memory banks: byte lane = address mod 4
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            logic [1:0] i;
            logic [31:0] sum;
            i = 2'(k) - ls_addr[1:0];
            sum = ls_addr + {30'd0, i};
            if (state_reg == ST_CLEAR)
            begin
                bank_row[k] = clr_reg;
                bank_we[k] = 1'b1;
                bank_wd[k] = 8'd0;
            end
            else
            begin
                bank_row[k] = sum[MEM_AW-1:2];
                bank_we[k] = ex_fire && st && ({1'b0, i} < (3'd1 << f3[1:0]));
                bank_wd[k] = b[8*i +: 8];
            end
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        rv32i_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (bank_row[g]),
            .wdata (bank_wd[g]),
            .re    (ld_go),
            .raddr (bank_row[g]),
            .rdata (bank_q[g])
        );
    end

    rv32i_ram #(.WIDTH(32), .DEPTH(NREGS)) u_rf_a (
        .clk   (clk),
        .we    (wb_en),
        .waddr (wb_idx),
        .wdata (wb_val),
        .re    (accept),
        .raddr (instruction[19:15]),
        .rdata (q1)
    );

    rv32i_ram #(.WIDTH(32), .DEPTH(NREGS)) u_rf_b (
        .clk   (clk),
        .we    (wb_en),
        .waddr (wb_idx),
        .wdata (wb_val),
        .re    (accept),
        .raddr (instruction[24:20]),
        .rdata (q2)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (ld_go)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                if (ld_fire)
                begin
                    state_next = ST_RUN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            pc_reg <= 32'd0;
            rv_reg <= '0;
            ex_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (wb_en)
            begin
                rv_reg[wb_idx] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                pc_reg <= start_pc;
            end
            else if (ex_fire || ld_go)
            begin
                pc_reg <= ill ? pc_reg + PC_STEP : npc;
            end
            if (accept)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_fire || ld_go)
            begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire || ld_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ins_reg <= instruction;
            v1_reg <= rv_reg[instruction[19:15]];
            v2_reg <= rv_reg[instruction[24:20]];
            f1_reg <= wb_en && (wb_idx == instruction[19:15]);
            f2_reg <= wb_en && (wb_idx == instruction[24:20]);
            fv1_reg <= wb_val;
            fv2_reg <= wb_val;
        end
        if (ld_go)
        begin
            ld_npc_reg <= pc_reg + PC_STEP;
            ld_rd_reg <= rd;
            ld_wr_reg <= wr;
            ld_f3_reg <= f3;
            ld_off_reg <= ls_addr[1:0];
        end
        if (ex_fire)
        begin
            next_pc <= ill ? pc_reg + PC_STEP : npc;
            reg_write <= wr && !ill;
            reg_index <= (wr && !ill) ? rd : 5'd0;
            reg_value <= (wr && !ill) ? val : 32'd0;
            branch_taken <= taken && !ill;
            store_valid <= st;
            store_address <= st ? ls_addr : 32'd0;
            store_data <= st ? b : 32'd0;
            store_size <= st ? f3[1:0] : 2'd0;
            illegal <= ill;
        end
        else if (ld_fire)
        begin
            next_pc <= ld_npc_reg;
            reg_write <= ld_wr_reg;
            reg_index <= ld_wr_reg ? ld_rd_reg : 5'd0;
            reg_value <= ld_wr_reg ? ld_val : 32'd0;
            branch_taken <= 1'b0;
            store_valid <= 1'b0;
            store_address <= 32'd0;
            store_data <= 32'd0;
            store_size <= 2'd0;
            illegal <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

FILE: dv/rv32i_instruction_executor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I executor checker
// Watches the config, instruction and result channels, keeps its own copy of
// pc, register file and data memory, and compares every result in order.
// ----------------------------------------------------------------------------
module rv32i_instruction_executor_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] start_pc,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [31:0] instruction,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] next_pc,
    input  logic        reg_write,
    input  logic [4:0]  reg_index,
    input  logic [31:0] reg_value,
    input  logic        branch_taken,
    input  logic        store_valid,
    input  logic [31:0] store_address,
    input  logic [31:0] store_data,
    input  logic [1:0]  store_size,
    input  logic        illegal,
    output int          fail_count,
    output int          pending
);
    import rv32i_pkg::*;

    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        taken;
        logic        st;
        logic [31:0] saddr;
        logic [31:0] sdata;
        logic [1:0]  ssize;
        logic        ill;
    } exec_result_t;

    logic [31:0]  pc_model;
    logic [31:0]  regs_model [NREGS];
    logic [7:0]   mem_model [MEM_BYTES];
    exec_result_t expected_q[$];

    assign pending = expected_q.size();

    function automatic logic [31:0] mem_get(logic [31:0] addr, int n);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
        begin
            v[8*i +: 8] = mem_model[(addr + i) % MEM_BYTES];
        end
        return v;
    endfunction

    function automatic logic [31:0] alu_op(logic [2:0] f3, logic alt, logic [31:0] a,
                                          logic [31:0] b);
        unique case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    // Executes one instruction on the model state and returns its result.
    function automatic exec_result_t execute(logic [31:0] ins);
        exec_result_t r;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] a, b, imm, addr, pc;
        int          n;
        r   = '0;
        pc  = pc_model;
        opc = ins[6:0];
        f3  = ins[14:12];
        f7  = ins[31:25];
        a   = (ins[19:15] == 0) ? 32'd0 : regs_model[ins[19:15]];
        b   = (ins[24:20] == 0) ? 32'd0 : regs_model[ins[24:20]];
        imm = {{20{ins[31]}}, ins[31:20]};
        r.npc = pc + PC_STEP;
        unique case (opc)
            OPC_OP:
            begin
                if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)))
                begin
                    r.val = alu_op(f3, f7 == F7_ALT, a, b);
                    r.wr  = 1'b1;
                end
                else
                begin
                    r.ill = 1'b1;
                end
            end
            OPC_OP_IMM:
            begin
                if (f3 == F3_SLL)
                begin
                    if (f7 == F7_BASE)
                    begin
                        r.val = alu_op(f3, 1'b0, a, imm & 32'd31);
                        r.wr  = 1'b1;
                    end
                    else
                    begin
                        r.ill = 1'b1;
                    end
                end
                else if (f3 == F3_SR)
                begin
                    if (f7 == F7_BASE || f7 == F7_ALT)
                    begin
                        r.val = alu_op(f3, f7 == F7_ALT, a, imm & 32'd31);
                        r.wr  = 1'b1;
                    end
                    else
                    begin
                        r.ill = 1'b1;
                    end
                end
                else
                begin
                    r.val = alu_op(f3, 1'b0, a, imm);
                    r.wr  = 1'b1;
                end
            end
            OPC_LOAD:
            begin
                addr = a + imm;
                r.wr = 1'b1;
                unique case (f3)
                    F3_LB:
                    begin
                        r.val = mem_get(addr, 1);
                        if (r.val[7])
                        begin
                            r.val |= BYTE_EXT;
                        end
                    end
                    F3_LH:
                    begin
                        r.val = mem_get(addr, 2);
                        if (r.val[15])
                        begin
                            r.val |= HALF_EXT;
                        end
                    end
                    F3_LW:   r.val = mem_get(addr, 4);
                    F3_LBU:  r.val = mem_get(addr, 1);
                    F3_LHU:  r.val = mem_get(addr, 2);
                    default:
                    begin
                        r.ill = 1'b1;
                        r.wr  = 1'b0;
                    end
                endcase
            end
            OPC_STORE:
            begin
                if (f3 <= 3'd2)
                begin
                    r.st    = 1'b1;
                    r.saddr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
                    r.sdata = b;
                    r.ssize = f3[1:0];
                    n = 1 << f3;
                    for (int i = 0; i < n; i++)
                    begin
                        mem_model[(r.saddr + i) % MEM_BYTES] = b[8*i +: 8];
                    end
                end
                else
                begin
                    r.ill = 1'b1;
                end
            end
            OPC_LUI:
            begin
                r.val = {ins[31:12], 12'd0};
                r.wr  = 1'b1;
            end
            OPC_AUIPC:
            begin
                r.val = pc + {ins[31:12], 12'd0};
                r.wr  = 1'b1;
            end
            OPC_JAL:
            begin
                r.npc   = pc + {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
                r.val   = pc + PC_STEP;
                r.wr    = 1'b1;
                r.taken = 1'b1;
            end
            OPC_JALR:
            begin
                if (f3 == 3'd0)
                begin
                    r.npc   = (a + imm) & ~32'd1;
                    r.val   = pc + PC_STEP;
                    r.wr    = 1'b1;
                    r.taken = 1'b1;
                end
                else
                begin
                    r.ill = 1'b1;
                end
            end
            OPC_BRANCH:
            begin
                unique case (f3)
                    F3_BEQ:  r.taken = a == b;
                    F3_BNE:  r.taken = a != b;
                    F3_BLT:  r.taken = $signed(a) < $signed(b);
                    F3_BGE:  r.taken = !($signed(a) < $signed(b));
                    F3_BLTU: r.taken = a < b;
                    F3_BGEU: r.taken = a >= b;
                    default: r.ill = 1'b1;
                endcase
                if (r.taken)
                begin
                    r.npc = pc + {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                end
            end
            default: r.ill = 1'b1;
        endcase
        if (r.ill)
        begin
            r = '0;
            r.ill = 1'b1;
            r.npc = pc + PC_STEP;
        end
        if (r.wr && ins[11:7] == 0)
        begin
            r.wr = 1'b0;
        end
        if (r.wr)
        begin
            r.rd = ins[11:7];
            regs_model[r.rd] = r.val;
        end
        else
        begin
            r.val = '0;
        end
        pc_model = r.npc;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        exec_result_t e;
        if (!rst_n)
        begin
            fail_count = 0;
            pc_model   = '0;
            expected_q.delete();
            for (int i = 0; i < NREGS; i++)
            begin
                regs_model[i] = '0;
            end
            for (int i = 0; i < MEM_BYTES; i++)
            begin
                mem_model[i] = '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pc_model = start_pc;
            end
            if (item_valid && !item_stall)
            begin
                expected_q.push_back(execute(instruction));
            end
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    check_field("next_pc", e.npc, next_pc);
                    check_field("reg_write", 32'(e.wr), 32'(reg_write));
                    check_field("reg_index", 32'(e.rd), 32'(reg_index));
                    check_field("reg_value", e.val, reg_value);
                    check_field("branch_taken", 32'(e.taken), 32'(branch_taken));
                    check_field("store_valid", 32'(e.st), 32'(store_valid));
                    check_field("store_address", e.saddr, store_address);
                    check_field("store_data", e.sdata, store_data);
                    check_field("store_size", 32'(e.ssize), 32'(store_size));
                    check_field("illegal", 32'(e.ill), 32'(illegal));
                end
            end
        end
    end

endmodule

FILE: dv/rv32i_instruction_executor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV32I executor testbench
// Drives directed and random instruction streams with random idling on both
// channels, reloads start_pc between phases, and reports the checker verdict.
// ----------------------------------------------------------------------------
module rv32i_instruction_executor_top_tb;
    import rv32i_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] start_pc;
    logic        item_valid;
    logic        item_stall;
    logic [31:0] instruction;
    logic        result_valid;
    logic        result_stall;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        branch_taken;
    logic        store_valid;
    logic [31:0] store_address;
    logic [31:0] store_data;
    logic [1:0]  store_size;
    logic        illegal;
    int          fail_count;
    int          pending;
    int          cycle_count;
    logic        calm;

    rv32i_instruction_executor_top DUT (.*);

    rv32i_instruction_executor_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stalls at random except during calm stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= !calm && ($urandom_range(99) < 33);
    end

    function automatic logic [31:0] rtype(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    // valid stays high from one item to the next unless an idle gap is drawn
    task automatic send(logic [31:0] ins);
        if (!calm && $urandom_range(99) < 33)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while (!calm && $urandom_range(99) < 33)
                @(posedge clk);
        end
        item_valid  <= 1'b1;
        instruction <= ins;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_start_pc(logic [31:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        start_pc  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed encodings over a few registers so state is reused.
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        logic [6:0]  opcs [9];
        logic [4:0]  rd, rs1, rs2;
        opcs = '{OPC_OP, OPC_OP_IMM, OPC_LOAD, OPC_STORE, OPC_LUI, OPC_AUIPC,
                 OPC_JAL, OPC_JALR, OPC_BRANCH};
        w = $urandom();
        if ($urandom_range(9) == 0)
            return w;
        rd  = ($urandom_range(3) == 0) ? 5'($urandom()) : 5'($urandom_range(7));
        rs1 = ($urandom_range(3) == 0) ? 5'($urandom()) : 5'($urandom_range(7));
        rs2 = ($urandom_range(3) == 0) ? 5'($urandom()) : 5'($urandom_range(7));
        w[6:0]   = opcs[$urandom_range(8)];
        w[11:7]  = rd;
        w[19:15] = rs1;
        w[24:20] = rs2;
        if (w[6:0] == OPC_OP || (w[6:0] == OPC_OP_IMM && (w[14:12] == F3_SLL
                || w[14:12] == F3_SR)))
            if ($urandom_range(7) != 0)
                w[31:25] = ($urandom_range(1) != 0) ? F7_ALT : F7_BASE;
        return w;
    endfunction

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        start_pc    = '0;
        item_valid  = 1'b0;
        instruction = '0;
        calm        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fill registers with extremes, then every operation class
        send({20'h80000, 5'd1, OPC_LUI});
        send({12'hFFF, 5'd0, F3_ADD, 5'd2, OPC_OP_IMM});
        send({12'h7FF, 5'd0, F3_ADD, 5'd3, OPC_OP_IMM});
        send({12'h001, 5'd0, F3_ADD, 5'd0, OPC_OP_IMM});
        for (int f = 0; f < 8; f++)
            send(rtype(F7_BASE, 5'd2, 5'd1, 3'(f), 5'd4, OPC_OP));
        send(rtype(F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd5, OPC_OP));
        send(rtype(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd5, OPC_OP));
        send(rtype(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd6, OPC_OP_IMM));
        send(rtype(7'h01, 5'd2, 5'd1, F3_ADD, 5'd6, OPC_OP));
        send(rtype(7'h7F, 5'd2, 5'd0, 3'd2, 5'd0, OPC_STORE));
        send(rtype(7'h00, 5'd0, 5'd0, F3_LB, 5'd7, OPC_LOAD));
        send(rtype(7'h7F, 5'd31, 5'd0, F3_LHU, 5'd7, OPC_LOAD));
        send(rtype(7'h00, 5'd0, 5'd0, 3'd3, 5'd7, OPC_LOAD));
        for (int f = 0; f < 8; f++)
            send(rtype(7'h40, 5'd2, 5'd1, 3'(f), 5'h1F, OPC_BRANCH));
        send({20'hFFFFF, 5'd8, OPC_JAL});
        send({12'hFFF, 5'd3, 3'd0, 5'd9, OPC_JALR});
        send({12'h000, 5'd0, 3'd1, 5'd9, OPC_JALR});
        send({20'hFFFFF, 5'd10, OPC_AUIPC});
        send(32'hFFFFFFFF);
        send(32'h0000000F);
        send(32'h00000073);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_start_pc(32'hFFFFFFFC);
                1: write_start_pc(32'h00000000);
                2: write_start_pc(32'hFFFFFFFF);
                default: write_start_pc($urandom());
            endcase
            for (int i = 0; i < 500; i++)
            begin
                calm <= (phase == 1 && i >= 200 && i < 350);
                send(random_instruction());
            end
        end
        calm <= 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rv32i_pkg.sv
hw/rtl/rv32i_ram.sv
hw/rtl/rv32i_instruction_executor_top.sv
dv/rv32i_instruction_executor_checker.sv
dv/rv32i_instruction_executor_top_tb.sv
